// ----- src/mfa_pkg.sv -----
// Shared types and codes for the mixed fraction arithmetic block.
package mfa_pkg;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_CMP = 3'd4
  } cmd_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Flag positions in the result tuser.
  localparam int FLAG_LESS = 0;
  localparam int FLAG_EQUAL = 1;
  localparam int FLAG_DBZ = 2;
  localparam int FLAG_OVF = 3;
  localparam int FLAG_BITS = 4;

endpackage

// ----- src/mfa_alu.sv -----
// Shared wide adder/subtractor used by the arithmetic steps of the sequencer.
module mfa_alu #(
  parameter int WIDTH = 130
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  mfa_pkg::alu_op_t op,
  output logic [WIDTH-1:0] sum
);

  logic [WIDTH-1:0] b_inv;

  always_comb begin
    if (op == mfa_pkg::ALU_SUB) begin
      b_inv = ~b;
    end else begin
      b_inv = b;
    end
  end

  assign sum = a + b_inv + WIDTH'(op == mfa_pkg::ALU_SUB);

endmodule

// ----- src/mixed_fraction_arithmetic.sv -----
// Mixed fraction add, subtract, multiply, divide and compare with gcd reduction.
// One item at a time: s_tready is high only while idle. All arithmetic runs on one
// shared adder of 4*WORD_BITS+2 bits: each product is a shift-add over the
// 2*WORD_BITS multiplier bits, the gcd is a binary (shift and subtract) search
// followed by the shift back, and the two exact divisions by the gcd and the final
// whole/remainder split are restoring divisions of 4*WORD_BITS quotient bits each.
// Compare, an unused command and a division by zero skip the gcd and the divisions;
// the output step then holds until the previous result has been taken, so a
// stalled receiver delays the next item.
module mixed_fraction_arithmetic #(
  parameter int WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // a_whole, a_num, a_den, b_whole, b_num, b_den (lowest first), zero padded
  input  logic [((6*WORD_BITS-2+7)/8)*8-1:0] s_tdata,
  // command
  input  logic [2:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // res_whole, res_num, res_den (lowest first), zero padded
  output logic [((3*WORD_BITS-1+7)/8)*8-1:0] m_tdata,
  // less, equal, divide_by_zero, overflow (lowest first)
  output logic [mfa_pkg::FLAG_BITS-1:0] m_tuser
);

  localparam int W = WORD_BITS;
  localparam int NW = 4*W;
  localparam int AW = NW+2;
  localparam int YW = 2*W;
  localparam int CW = $clog2(NW);
  localparam int KW = $clog2(NW+1);
  localparam int OUT_BITS = 3*W-1;
  localparam int OUT_TW = ((OUT_BITS+7)/8)*8;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_DIV, S_VA, S_VB, S_L, S_R, S_MN, S_DVN, S_DD,
    S_NEGN, S_NEGD, S_G0, S_G1, S_GK, S_Q1, S_Q2, S_FIN, S_PUT
  } state_t;

  state_t state, ret;
  mfa_pkg::cmd_t cmd;
  logic signed [W-1:0] aw, an, bw, bn;
  logic [W-2:0] ad, bd;
  logic [YW-1:0] va, vb, my;
  logic [NW-1:0] mx, p, nreg, dreg, u, v;
  logic [CW-1:0] cnt;
  logic [KW-1:0] k;
  logic neg;
  logic [W-1:0] rw, rn;
  logic [W-2:0] rd;
  logic [mfa_pkg::FLAG_BITS-1:0] rf;
  logic [mfa_pkg::FLAG_BITS-1:0] dbz_flag;
  logic [W-1:0] res_whole, res_num;
  logic [W-2:0] res_den;

  logic [AW-1:0] alu_a, alu_b, alu_sum;
  mfa_pkg::alu_op_t alu_op;

  logic [W-1:0] in_aw, in_an, in_bw, in_bn;
  logic [W-2:0] in_ad, in_bd;
  logic [YW-1:0] vbn;
  logic borrow;
  logic d_ovf, q_ovf;
  logic [NW-1:0] q_min;

  assign in_aw = s_tdata[W-1:0];
  assign in_an = s_tdata[2*W-1:W];
  assign in_ad = s_tdata[3*W-2:2*W];
  assign in_bw = s_tdata[4*W-2:3*W-1];
  assign in_bn = s_tdata[5*W-2:4*W-1];
  assign in_bd = s_tdata[6*W-3:5*W-1];

  assign vbn = alu_sum[YW-1:0];
  assign borrow = alu_sum[AW-1];
  assign q_min = NW'(1) << (W-1);
  assign d_ovf = |dreg[NW-1:W-1];
  assign q_ovf = (|u[NW-1:W-1]) && !(neg && (u == q_min));

  always_comb begin
    dbz_flag = '0;
    dbz_flag[mfa_pkg::FLAG_DBZ] = 1'b1;
  end

  mfa_alu #(.WIDTH(AW)) u_alu (
    .a(alu_a),
    .b(alu_b),
    .op(alu_op),
    .sum(alu_sum)
  );

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_op = mfa_pkg::ALU_SUB;
    case (state)
      S_MUL: begin
        // MSB of the multiplier carries negative weight
        if (cnt != CW'(YW-1)) begin
          alu_a = {2'b00, p[NW-2:0], 1'b0};
        end
        if (my[YW-1]) begin
          alu_b = {2'b00, mx};
        end
        alu_op = (cnt == CW'(YW-1)) ? mfa_pkg::ALU_SUB : mfa_pkg::ALU_ADD;
      end
      S_DIV: begin
        alu_a = {1'b0, p, u[NW-1]};
        alu_b = {2'b00, mx};
      end
      S_VA: begin
        alu_a = {2'b00, p};
        alu_b = {2'b00, {(NW-W){an[W-1]}}, an};
        alu_op = aw[W-1] ? mfa_pkg::ALU_SUB : mfa_pkg::ALU_ADD;
      end
      S_VB: begin
        alu_a = {2'b00, p};
        alu_b = {2'b00, {(NW-W){bn[W-1]}}, bn};
        alu_op = bw[W-1] ? mfa_pkg::ALU_SUB : mfa_pkg::ALU_ADD;
      end
      S_R: begin
        alu_a = {2'b00, nreg};
        alu_b = {2'b00, p};
        alu_op = (cmd == mfa_pkg::CMD_ADD) ? mfa_pkg::ALU_ADD : mfa_pkg::ALU_SUB;
      end
      S_NEGN: alu_b = {2'b00, nreg};
      S_NEGD: alu_b = {2'b00, dreg};
      S_G1: begin
        alu_a = {2'b00, u};
        alu_b = {2'b00, v};
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_PUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd <= mfa_pkg::cmd_t'(s_tuser);
            aw <= in_aw;
            an <= in_an;
            bw <= in_bw;
            bn <= in_bn;
            ad <= (in_ad == '0) ? (W-1)'(1) : in_ad;
            bd <= (in_bd == '0) ? (W-1)'(1) : in_bd;
            mx <= {{(NW-W){in_aw[W-1]}}, in_aw};
            my <= {{(YW-W+1){1'b0}}, ((in_ad == '0) ? (W-1)'(1) : in_ad)};
            cnt <= CW'(YW-1);
            ret <= S_VA;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p <= alu_sum[NW-1:0];
          my <= {my[YW-2:0], 1'b0};
          if (cnt == '0) begin
            state <= ret;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        S_DIV: begin
          if (!borrow) begin
            p <= alu_sum[NW-1:0];
          end else begin
            p <= {p[NW-2:0], u[NW-1]};
          end
          u <= {u[NW-2:0], !borrow};
          if (cnt == '0) begin
            state <= ret;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        S_VA: begin
          va <= alu_sum[YW-1:0];
          mx <= {{(NW-W){bw[W-1]}}, bw};
          my <= {{(YW-W+1){1'b0}}, bd};
          cnt <= CW'(YW-1);
          ret <= S_VB;
          state <= S_MUL;
        end
        S_VB: begin
          vb <= vbn;
          mx <= {{(NW-YW){va[YW-1]}}, va};
          cnt <= CW'(YW-1);
          rw <= '0;
          rn <= '0;
          rd <= (W-1)'(1);
          case (cmd)
            mfa_pkg::CMD_ADD, mfa_pkg::CMD_SUB, mfa_pkg::CMD_CMP: begin
              my <= {{(YW-W+1){1'b0}}, bd};
              rf <= '0;
              ret <= S_L;
              state <= S_MUL;
            end
            mfa_pkg::CMD_MUL: begin
              my <= vbn;
              rf <= '0;
              ret <= S_MN;
              state <= S_MUL;
            end
            mfa_pkg::CMD_DIV: begin
              my <= {{(YW-W+1){1'b0}}, bd};
              if (vbn == '0) begin
                rf <= dbz_flag;
                state <= S_PUT;
              end else begin
                rf <= '0;
                ret <= S_DVN;
                state <= S_MUL;
              end
            end
            default: begin
              my <= {{(YW-W+1){1'b0}}, bd};
              rf <= '0;
              state <= S_PUT;
            end
          endcase
        end
        S_L: begin
          nreg <= p;
          mx <= {{(NW-YW){vb[YW-1]}}, vb};
          my <= {{(YW-W+1){1'b0}}, ad};
          cnt <= CW'(YW-1);
          ret <= S_R;
          state <= S_MUL;
        end
        S_R: begin
          if (cmd == mfa_pkg::CMD_CMP) begin
            rf[mfa_pkg::FLAG_LESS] <= alu_sum[NW-1];
            rf[mfa_pkg::FLAG_EQUAL] <= (alu_sum[NW-1:0] == '0);
            state <= S_PUT;
          end else begin
            nreg <= alu_sum[NW-1:0];
            mx <= {{(NW-W+1){1'b0}}, ad};
            my <= {{(YW-W+1){1'b0}}, bd};
            cnt <= CW'(YW-1);
            ret <= S_DD;
            state <= S_MUL;
          end
        end
        S_MN: begin
          nreg <= p;
          mx <= {{(NW-W+1){1'b0}}, ad};
          my <= {{(YW-W+1){1'b0}}, bd};
          cnt <= CW'(YW-1);
          ret <= S_DD;
          state <= S_MUL;
        end
        S_DVN: begin
          // denominator may come out negative here; sign is fixed below
          nreg <= p;
          mx <= {{(NW-W+1){1'b0}}, ad};
          my <= vb;
          cnt <= CW'(YW-1);
          ret <= S_DD;
          state <= S_MUL;
        end
        S_DD: begin
          dreg <= p;
          state <= S_NEGN;
        end
        S_NEGN: begin
          neg <= nreg[NW-1] ^ dreg[NW-1];
          if (nreg[NW-1]) begin
            nreg <= alu_sum[NW-1:0];
          end
          state <= S_NEGD;
        end
        S_NEGD: begin
          u <= nreg;
          k <= '0;
          if (dreg[NW-1]) begin
            dreg <= alu_sum[NW-1:0];
            v <= alu_sum[NW-1:0];
          end else begin
            v <= dreg;
          end
          state <= S_G0;
        end
        S_G0: begin
          // strip common factors of two
          if (u == '0) begin
            state <= S_GK;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + KW'(1);
          end else begin
            state <= S_G1;
          end
        end
        S_G1: begin
          if (u == '0) begin
            state <= S_GK;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (!borrow) begin
            u <= alu_sum[NW-1:0];
          end else begin
            u <= v;
            v <= u;
          end
        end
        S_GK: begin
          if (k != '0) begin
            v <= v << 1;
            k <= k - KW'(1);
          end else begin
            mx <= v;
            u <= nreg;
            p <= '0;
            cnt <= CW'(NW-1);
            ret <= S_Q1;
            state <= S_DIV;
          end
        end
        S_Q1: begin
          nreg <= u;
          u <= dreg;
          p <= '0;
          cnt <= CW'(NW-1);
          ret <= S_Q2;
          state <= S_DIV;
        end
        S_Q2: begin
          dreg <= u;
          mx <= u;
          u <= nreg;
          p <= '0;
          cnt <= CW'(NW-1);
          ret <= S_FIN;
          state <= S_DIV;
        end
        S_FIN: begin
          if (d_ovf || q_ovf) begin
            rf[mfa_pkg::FLAG_OVF] <= 1'b1;
          end else begin
            rw <= neg ? (W'(0) - u[W-1:0]) : u[W-1:0];
            rn <= ((u == '0) && neg) ? (W'(0) - p[W-1:0]) : p[W-1:0];
            rd <= dreg[W-2:0];
          end
          state <= S_PUT;
        end
        S_PUT: begin
          if (!m_tvalid || m_tready) begin
            res_whole <= rw;
            res_num <= rn;
            res_den <= rd;
            m_tuser <= rf;
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {{(OUT_TW-OUT_BITS){1'b0}}, res_den, res_num, res_whole};

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while busy");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(m_tuser) <= 1))
    else $error("more than one result flag");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != '0)) |-> (res_whole == '0 && res_num == '0 && res_den == 1))
    else $error("flagged result carries a value");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res_den != '0))
    else $error("zero denominator");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid) && (state == S_IDLE)) |-> $past(state == S_PUT))
    else $error("result loaded outside the output step");

endmodule
